// File: design/cbt_pkg.sv
// Shared widths and types for the cubic Bezier tessellator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cbt_pkg;

  localparam int COORD_W = 32;  // Q16.16 coordinate
  localparam int U_W     = 17;  // Q0.16 parameter, 65536 stands for 1.0
  localparam int SQ_W    = 34;  // product of two parameters
  localparam int B_W     = 49;  // Bernstein weight in Q0.48
  localparam int W_W     = 33;  // rounded weight in Q0.32
  localparam int PROD_W  = 66;  // weight times coordinate
  localparam int SUM_W   = 68;  // sum of four lane products
  localparam int RAD_W   = 64;  // radicand of the segment length
  localparam int ROOT_W  = 32;
  localparam int LEN_W   = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int DEN_W   = 6;

  localparam logic [U_W-1:0] U_ONE = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [U_W-1:0]            param_t;
  typedef logic [W_W-1:0]            weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage
`default_nettype wire

// File: design/cbt_udiv.sv
// Restoring divider that splits one Q0.16 step of 1.0 over the segment count.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbt_udiv (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [cbt_pkg::DEN_W-1:0] den,
  output logic                     done,
  output logic [cbt_pkg::U_W-1:0]  quot,
  output logic [cbt_pkg::DEN_W-1:0] rmd
);
  import cbt_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  logic [U_W-1:0]   quot_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, most significant first.
  assign trial = {rem_r, U_ONE[cnt_r]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(U_W - 1);
        quot_r <= '0;
        rem_r  <= '0;
        den_r  <= den;
      end else if (busy_r) begin
        if (fits) begin
          rem_r  <= DEN_W'(trial - {1'b0, den_r});
          quot_r <= {quot_r[U_W-2:0], 1'b1};
        end else begin
          rem_r  <= trial[DEN_W-1:0];
          quot_r <= {quot_r[U_W-2:0], 1'b0};
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rmd  = rem_r;

endmodule
`default_nettype wire

// File: design/cbt_isqrt.sv
// Bit-by-bit integer square root of a 64-bit radicand, one result bit a cycle.
// Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbt_isqrt (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [cbt_pkg::RAD_W-1:0]  rad,
  output logic                      done,
  output logic [cbt_pkg::ROOT_W-1:0] root
);
  import cbt_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [RAD_W-1:0] num_r;
  logic [RAD_W-1:0] res_r;
  logic [RAD_W-1:0] bit_r;
  logic [RAD_W-1:0] trial;

  assign trial = res_r + bit_r;

  // Each step settles one bit of the root from the top down.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= rad;
        res_r  <= '0;
        bit_r  <= {2'b01, {(RAD_W-2){1'b0}}};
      end else if (busy_r) begin
        if (num_r >= trial) begin
          num_r <= num_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule
`default_nettype wire

// File: design/cbt_lane.sv
// One control-point lane: multiplies its x and y by the point's weight.
// The 33-bit weight is split into two partial products. Depends on cbt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cbt_lane (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  input  cbt_pkg::weight_t  w,
  input  cbt_pkg::coord_t   px,
  input  cbt_pkg::coord_t   py,
  output logic              done,
  output cbt_pkg::prod_t    prod_x,
  output cbt_pkg::prod_t    prod_y
);
  import cbt_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;
  localparam logic [1:0] PH_ADD  = 2'd3;

  logic [1:0]         ph_r;
  logic               done_r;
  logic signed [49:0] hi_x_r, hi_y_r;
  logic signed [48:0] lo_x_r, lo_y_r;
  prod_t              prod_x_r, prod_y_r;

  // Upper weight bits first, then lower bits, then the aligned sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
          if (start) ph_r <= PH_HI;
        end
        PH_HI: begin
          hi_x_r <= $signed({1'b0, w[W_W-1:16]}) * px;
          hi_y_r <= $signed({1'b0, w[W_W-1:16]}) * py;
          ph_r   <= PH_LO;
        end
        PH_LO: begin
          lo_x_r <= $signed({1'b0, w[15:0]}) * px;
          lo_y_r <= $signed({1'b0, w[15:0]}) * py;
          ph_r   <= PH_ADD;
        end
        PH_ADD: begin
          prod_x_r <= (PROD_W'(hi_x_r) <<< 16) + PROD_W'(lo_x_r);
          prod_y_r <= (PROD_W'(hi_y_r) <<< 16) + PROD_W'(lo_y_r);
          done_r   <= 1'b1;
          ph_r     <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign done   = done_r;
  assign prod_x = prod_x_r;
  assign prod_y = prod_y_r;

endmodule
`default_nettype wire

// File: design/cubic_bezier_tessellator_top.sv
// Cubic Bezier tessellator: sequencer, weight unit, four lanes and merge.
// Depends on cbt_pkg, cbt_udiv, cbt_lane and cbt_isqrt.
`timescale 1ns / 1ps
`default_nettype none
// Each request carries one cubic curve and a sample count N (2 to MAX_POINTS,
// other values clamped). The block returns N points in order, each with its
// index, a last flag and the saturating running polyline length. Four lanes,
// one per control point, form the weighted products and a merge stage sums,
// rounds and saturates them. A request first runs the step division, then
// computes its points in order; every point after the first spends most of
// its time in the 32-step square root of the segment length. A new request
// is taken once the last point of the previous one has been placed in the
// output register.
module cubic_bezier_tessellator_top #(
  parameter int MAX_POINTS = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  cbt_pkg::coord_t            in_p0_x,
  input  cbt_pkg::coord_t            in_p0_y,
  input  cbt_pkg::coord_t            in_p1_x,
  input  cbt_pkg::coord_t            in_p1_y,
  input  cbt_pkg::coord_t            in_p2_x,
  input  cbt_pkg::coord_t            in_p2_y,
  input  cbt_pkg::coord_t            in_p3_x,
  input  cbt_pkg::coord_t            in_p3_y,
  input  wire [cbt_pkg::CNT_W-1:0]   in_num_points,
  output logic                       out_valid,
  input  wire                        out_ready,
  output cbt_pkg::coord_t            out_point_x,
  output cbt_pkg::coord_t            out_point_y,
  output logic [cbt_pkg::IDX_W-1:0]  out_point_index,
  output logic                       out_is_last,
  output logic [cbt_pkg::LEN_W-1:0]  out_path_length
);
  import cbt_pkg::*;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POINTS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_WA   = 4'd2;
  localparam logic [3:0] S_WB   = 4'd3;
  localparam logic [3:0] S_WC   = 4'd4;
  localparam logic [3:0] S_LS   = 4'd5;
  localparam logic [3:0] S_LW   = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_RND  = 4'd8;
  localparam logic [3:0] S_SQ   = 4'd9;
  localparam logic [3:0] S_SR   = 4'd10;
  localparam logic [3:0] S_SW   = 4'd11;
  localparam logic [3:0] S_EMIT = 4'd12;

  // Round half up from Q32 fraction and clamp to the signed 32-bit range.
  function automatic coord_t rnd_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-33:0] r;
    t = s + (SUM_W'(1) <<< 31);
    r = (SUM_W-32)'(t >>> 32);
    if (r > (SUM_W-32)'(32'sh7FFFFFFF)) rnd_sat = 32'sh7FFFFFFF;
    else if (r < -(SUM_W-32)'(33'sh080000000)) rnd_sat = 32'sh80000000;
    else rnd_sat = r[COORD_W-1:0];
  endfunction

  logic [3:0]         state_r;
  coord_t             px_r [4];
  coord_t             py_r [4];
  logic [DEN_W-1:0]   den_r;
  logic [IDX_W-1:0]   k_r;
  param_t             u_r;
  param_t             q0_r;
  logic [DEN_W-1:0]   r0_r;
  logic [DEN_W-1:0]   rem_r;
  logic [SQ_W-1:0]    uu_r, vv_r, uv_r;
  logic [B_W-1:0]     t_r [4];
  weight_t            w_r [4];
  logic signed [SUM_W-1:0] sum_x_r, sum_y_r;
  coord_t             x_r, y_r, prev_x_r, prev_y_r;
  logic [RAD_W-1:0]   sqx_r, sqy_r;
  logic               big_r;
  logic [LEN_W-1:0]   total_r;

  logic               out_valid_r;
  coord_t             out_x_r, out_y_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic               out_last_r;
  logic [LEN_W-1:0]   out_len_r;

  logic               accept;
  logic [CNT_W-1:0]   n_clamp;
  logic [DEN_W-1:0]   den_in;
  param_t             v;
  logic [50:0]        m0, m1, m2, m3;
  logic [B_W:0]       b_rnd [4];
  logic               div_done;
  param_t             div_q;
  logic [DEN_W-1:0]   div_r;
  logic [3:0]         lane_done;
  prod_t              lane_px [4];
  prod_t              lane_py [4];
  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]   ax, ay;
  logic               big;
  logic [COORD_W-1:0] sx, sy;
  logic               sq_done;
  logic [ROOT_W-1:0]  root;
  logic [ROOT_W:0]    seg;
  logic [ROOT_W+1:0]  tot;
  logic [DEN_W:0]     rem2;
  logic               out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Clamp the sample count and form the segment count.
  always_comb begin
    if (in_num_points < CNT_W'(2)) n_clamp = CNT_W'(2);
    else if (in_num_points > MAX_N) n_clamp = MAX_N;
    else n_clamp = in_num_points;
  end
  assign den_in = DEN_W'(n_clamp - CNT_W'(1));

  cbt_udiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (accept),
    .den   (den_in),
    .done  (div_done),
    .quot  (div_q),
    .rmd   (div_r)
  );

  // Bernstein products; each feeds a register before the next multiply.
  assign v  = U_ONE - u_r;
  assign m0 = vv_r * v;
  assign m1 = uv_r * v;
  assign m2 = uv_r * u_r;
  assign m3 = uu_r * u_r;

  // Weights times three where needed, rounded from Q0.48 to Q0.32.
  always_comb begin
    b_rnd[0] = {1'b0, t_r[0]} + (B_W+1)'(32768);
    b_rnd[1] = {1'b0, t_r[1]} + {t_r[1], 1'b0} + (B_W+1)'(32768);
    b_rnd[2] = {1'b0, t_r[2]} + {t_r[2], 1'b0} + (B_W+1)'(32768);
    b_rnd[3] = {1'b0, t_r[3]} + (B_W+1)'(32768);
  end

  // Four lanes, one for each control point.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    cbt_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (state_r == S_LS),
      .w      (w_r[g]),
      .px     (px_r[g]),
      .py     (py_r[g]),
      .done   (lane_done[g]),
      .prod_x (lane_px[g]),
      .prod_y (lane_py[g])
    );
  end

  // Segment vector; halve both components when either is too wide to square.
  assign dx  = {x_r[COORD_W-1], x_r} - {prev_x_r[COORD_W-1], prev_x_r};
  assign dy  = {y_r[COORD_W-1], y_r} - {prev_y_r[COORD_W-1], prev_y_r};
  assign ax  = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
  assign ay  = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
  assign big = (|ax[COORD_W:COORD_W-1]) || (|ay[COORD_W:COORD_W-1]);
  assign sx  = big ? ax[COORD_W:1] : ax[COORD_W-1:0];
  assign sy  = big ? ay[COORD_W:1] : ay[COORD_W-1:0];

  cbt_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_SR),
    .rad   (sqx_r + sqy_r),
    .done  (sq_done),
    .root  (root)
  );

  assign seg  = big_r ? {root, 1'b0} : {1'b0, root};
  assign tot  = {2'b00, total_r} + {1'b0, seg};
  assign rem2 = {1'b0, rem_r} + {1'b0, r0_r};

  // Sequencer over the samples of one curve.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_valid_r && out_ready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            px_r[0] <= in_p0_x;  py_r[0] <= in_p0_y;
            px_r[1] <= in_p1_x;  py_r[1] <= in_p1_y;
            px_r[2] <= in_p2_x;  py_r[2] <= in_p2_y;
            px_r[3] <= in_p3_x;  py_r[3] <= in_p3_y;
            den_r   <= den_in;
            k_r     <= '0;
            u_r     <= '0;
            total_r <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            q0_r    <= div_q;
            r0_r    <= div_r;
            rem_r   <= den_r >> 1;
            state_r <= S_WA;
          end
        end
        S_WA: begin
          uu_r    <= u_r * u_r;
          vv_r    <= v * v;
          uv_r    <= u_r * v;
          state_r <= S_WB;
        end
        S_WB: begin
          t_r[0]  <= m0[B_W-1:0];
          t_r[1]  <= m1[B_W-1:0];
          t_r[2]  <= m2[B_W-1:0];
          t_r[3]  <= m3[B_W-1:0];
          state_r <= S_WC;
        end
        S_WC: begin
          for (int i = 0; i < 4; i++) w_r[i] <= b_rnd[i][B_W-1:16];
          state_r <= S_LS;
        end
        S_LS: state_r <= S_LW;
        S_LW: begin
          if (lane_done[0]) state_r <= S_SUM;
        end
        S_SUM: begin
          sum_x_r <= SUM_W'(lane_px[0]) + SUM_W'(lane_px[1])
                   + SUM_W'(lane_px[2]) + SUM_W'(lane_px[3]);
          sum_y_r <= SUM_W'(lane_py[0]) + SUM_W'(lane_py[1])
                   + SUM_W'(lane_py[2]) + SUM_W'(lane_py[3]);
          state_r <= S_RND;
        end
        S_RND: begin
          x_r     <= rnd_sat(sum_x_r);
          y_r     <= rnd_sat(sum_y_r);
          state_r <= (k_r == '0) ? S_EMIT : S_SQ;
        end
        S_SQ: begin
          sqx_r   <= sx * sx;
          sqy_r   <= sy * sy;
          big_r   <= big;
          state_r <= S_SR;
        end
        S_SR: state_r <= S_SW;
        S_SW: begin
          if (sq_done) begin
            total_r <= (tot[ROOT_W+1:LEN_W] != '0) ? '1 : tot[LEN_W-1:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= x_r;
            out_y_r     <= y_r;
            out_idx_r   <= k_r;
            out_last_r  <= (k_r == den_r);
            out_len_r   <= total_r;
            prev_x_r    <= x_r;
            prev_y_r    <= y_r;
            if (k_r == den_r) begin
              state_r <= S_IDLE;
            end else begin
              k_r <= k_r + IDX_W'(1);
              if (rem2 >= {1'b0, den_r}) begin
                rem_r <= DEN_W'(rem2 - {1'b0, den_r});
                u_r   <= u_r + q0_r + U_W'(1);
              end else begin
                rem_r <= rem2[DEN_W-1:0];
                u_r   <= u_r + q0_r;
              end
              state_r <= S_WA;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = out_x_r;
  assign out_point_y     = out_y_r;
  assign out_point_index = out_idx_r;
  assign out_is_last     = out_last_r;
  assign out_path_length = out_len_r;

endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the cubic Bezier tessellator.
// Depends on cbt_pkg and cubic_bezier_tessellator_top; predicts every sampled point.
`timescale 1ns / 1ps
module tb;
  import cbt_pkg::*;

  typedef struct {
    coord_t            x;
    coord_t            y;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic [LEN_W-1:0]  len;
  } curve_point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  coord_t in_p0_x = '0, in_p0_y = '0, in_p1_x = '0, in_p1_y = '0;
  coord_t in_p2_x = '0, in_p2_y = '0, in_p3_x = '0, in_p3_y = '0;
  logic [CNT_W-1:0] in_num_points = 7'd2;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_point_x, out_point_y;
  logic [IDX_W-1:0] out_point_index;
  logic out_is_last;
  logic [LEN_W-1:0] out_path_length;

  curve_point_t pending_points[$];
  int errors = 0;
  int send_gap_max = 7;
  int recv_stall_max = 7;
  int hold_cycles = 0;

  cubic_bezier_tessellator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_p0_x(in_p0_x), .in_p0_y(in_p0_y), .in_p1_x(in_p1_x), .in_p1_y(in_p1_y),
    .in_p2_x(in_p2_x), .in_p2_y(in_p2_y), .in_p3_x(in_p3_x), .in_p3_y(in_p3_y),
    .in_num_points(in_num_points),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_point_x(out_point_x), .out_point_y(out_point_y),
    .out_point_index(out_point_index), .out_is_last(out_is_last),
    .out_path_length(out_path_length)
  );

  always #1 clk = ~clk;

  // Integer square root, bit by bit.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Weighted blend of four coordinates, rounded half up and saturated.
  function automatic coord_t blend_coord(input coord_t c[4], input weight_t w[4]);
    logic signed [127:0] acc;
    logic signed [127:0] wt;
    logic signed [127:0] cc;
    int i;
    acc = '0;
    for (i = 0; i < 4; i++) begin
      wt = $signed({95'd0, w[i]});
      cc = c[i];
      acc = acc + wt * cc;
    end
    acc = (acc + (128'sd1 <<< 31)) >>> 32;
    if (acc > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (acc < -128'sd2147483648) return 32'h8000_0000;
    return acc[31:0];
  endfunction

  // Works out every point of one curve and queues it.
  task automatic predict_curve(input coord_t cx[4], input coord_t cy[4],
                               input logic [CNT_W-1:0] count);
    int n;
    longint unsigned den, u, v, b, total, seg, ax, ay;
    longint dx, dy, prev_x, prev_y;
    weight_t w[4];
    curve_point_t pt;
    int k;
    n = count;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    den = n - 1;
    total = 0;
    prev_x = 0;
    prev_y = 0;
    for (k = 0; k < n; k++) begin
      u = (k * 65536 + den / 2) / den;
      v = 65536 - u;
      b = v * v * v;     w[0] = W_W'((b + 32768) >> 16);
      b = 3 * u * v * v; w[1] = W_W'((b + 32768) >> 16);
      b = 3 * u * u * v; w[2] = W_W'((b + 32768) >> 16);
      b = u * u * u;     w[3] = W_W'((b + 32768) >> 16);
      pt.x = blend_coord(cx, w);
      pt.y = blend_coord(cy, w);
      if (k > 0) begin
        dx = longint'(pt.x) - prev_x;
        dy = longint'(pt.y) - prev_y;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax < 64'h8000_0000 && ay < 64'h8000_0000) begin
          seg = int_sqrt(ax * ax + ay * ay);
        end else begin
          ax = ax >> 1;
          ay = ay >> 1;
          seg = 2 * int_sqrt(ax * ax + ay * ay);
        end
        total = total + seg;
        if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      end
      prev_x = pt.x;
      prev_y = pt.y;
      pt.idx = IDX_W'(k);
      pt.last = (k == n - 1);
      pt.len = total[31:0];
      pending_points.push_back(pt);
    end
  endtask

  // Offers one curve request and returns at the edge that accepts it.
  task automatic send_curve(input coord_t cx[4], input coord_t cy[4],
                            input logic [CNT_W-1:0] count);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_p0_x <= cx[0]; in_p0_y <= cy[0]; in_p1_x <= cx[1]; in_p1_y <= cy[1];
    in_p2_x <= cx[2]; in_p2_y <= cy[2]; in_p3_x <= cx[3]; in_p3_y <= cy[3];
    in_num_points <= count;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_curve(cx, cy, count);
  endtask

  // Drops the request line and waits until every point has come back.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic rand_coords(output coord_t cx[4], output coord_t cy[4], input int span);
    int i;
    for (i = 0; i < 4; i++) begin
      if (span == 0) begin
        cx[i] = $urandom;
        cy[i] = $urandom;
      end else begin
        cx[i] = $signed($urandom_range(2 * span, 0)) - span;
        cy[i] = $signed($urandom_range(2 * span, 0)) - span;
      end
    end
  endtask

  // Full-scale coordinates, zero curves and the extreme corners.
  task automatic test_extremes;
    coord_t cx[4], cy[4];
    cx = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    cy = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    send_curve(cx, cy, 7'd64);
    cx = '{32'h0, 32'h0, 32'h0, 32'h0};
    cy = '{32'h0, 32'h0, 32'h0, 32'h0};
    send_curve(cx, cy, 7'd5);
    cx = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    cy = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send_curve(cx, cy, 7'd3);
    cx = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    cy = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    send_curve(cx, cy, 7'd17);
    cx = '{32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001};
    cy = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
    send_curve(cx, cy, 7'd9);
    drain();
  endtask

  // Counts below two, above the maximum and at the edges of the range.
  task automatic test_counts;
    coord_t cx[4], cy[4];
    logic [CNT_W-1:0] counts[10];
    int i;
    counts = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127, 7'd42, 7'd21};
    for (i = 0; i < 10; i++) begin
      rand_coords(cx, cy, (i % 2) ? 0 : 32'h0100_0000);
      send_curve(cx, cy, counts[i]);
    end
    drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure;
    coord_t cx[4], cy[4];
    int i;
    hold_cycles = 600;
    send_gap_max = 0;
    for (i = 0; i < 5; i++) begin
      rand_coords(cx, cy, 32'h0010_0000);
      send_curve(cx, cy, 7'($urandom_range(8, 2)));
    end
    send_gap_max = 7;
    drain();
  endtask

  // The sender pauses until every point is back before the next request.
  task automatic test_pause;
    coord_t cx[4], cy[4];
    rand_coords(cx, cy, 0);
    send_curve(cx, cy, 7'd6);
    drain();
    rand_coords(cx, cy, 0);
    send_curve(cx, cy, 7'd4);
    drain();
  endtask

  // Random curves, mostly short, with some long and some out-of-range counts.
  task automatic test_random;
    coord_t cx[4], cy[4];
    logic [CNT_W-1:0] count;
    int i, pick;
    for (i = 0; i < 150; i++) begin
      if (i == 50) begin
        send_gap_max = 0;
        recv_stall_max = 0;
      end
      if (i == 80) begin
        send_gap_max = 7;
        recv_stall_max = 7;
      end
      pick = $urandom_range(99, 0);
      if (pick < 6) count = 7'd64;
      else if (pick < 10) count = 7'($urandom_range(127, 0));
      else count = 7'($urandom_range(16, 2));
      rand_coords(cx, cy, ($urandom_range(1, 0)) ? 0 : 32'h0040_0000);
      send_curve(cx, cy, count);
    end
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_counts();
    test_backpressure();
    test_pause();
    test_random();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold when asked for.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = $urandom_range(recv_stall_max, 0);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compares each accepted point with the oldest expected one.
  always @(posedge clk) begin
    curve_point_t exp_pt;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point, expected none, actual x=%h y=%h", $time,
                 out_point_x, out_point_y);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (out_point_x !== exp_pt.x || out_point_y !== exp_pt.y
            || out_point_index !== exp_pt.idx || out_is_last !== exp_pt.last
            || out_path_length !== exp_pt.len) begin
          $display("%0t: mismatch expected x=%h y=%h idx=%0d last=%b len=%h", $time,
                   exp_pt.x, exp_pt.y, exp_pt.idx, exp_pt.last, exp_pt.len);
          $display("%0t:          actual   x=%h y=%h idx=%0d last=%b len=%h", $time,
                   out_point_x, out_point_y, out_point_index, out_is_last,
                   out_path_length);
          errors++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #8_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule
